// ===== hw/rtl/checksummed_frame_builder_ff_stuffing_assert.svh =====
// assertion macros for the checksummed frame builder
`ifndef CHECKSUMMED_FRAME_BUILDER_FF_STUFFING_ASSERT_SVH
`define CHECKSUMMED_FRAME_BUILDER_FF_STUFFING_ASSERT_SVH

// checked only while out of reset
`define CFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cfb_pkg.sv =====
// shared types and constants of the checksummed frame builder
package cfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] STUFF_TRIGGER = 8'hFF;
  localparam logic [7:0] STUFF_BYTE    = 8'h55;
  localparam logic [7:0] LEN_OFFSET    = 8'd8;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;

  // header positions inside the back sequencer
  localparam logic [3:0] HEAD_SECOND_IDX = 4'd1;
  localparam logic [3:0] HEAD_LEN_IDX    = 4'd2;
  localparam logic [3:0] HEAD_LAST_IDX   = 4'd9;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } action_e;

  typedef enum logic {
    REG_FIRST_HDR  = 1'b0,
    REG_SECOND_HDR = 1'b1
  } reg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE        = 5'b00001,
    ST_HEAD        = 5'b00010,
    ST_DATA_STUFF  = 5'b00100,
    ST_CSUM        = 5'b01000,
    ST_CSUM_STUFF  = 5'b10000
  } back_state_e;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic       start;   // frame header record
    logic [7:0] byte_a;  // length byte on start, payload byte otherwise
    logic [7:0] cmd;     // command byte, start only
    logic       stuff;   // payload byte needs a trailing stuff byte
    logic       close;   // checksum follows this record
    logic [7:0] csum;    // checksum value when close is set
  } rec_t;

endpackage

// ===== hw/rtl/cfb_front.sv =====
// front end: accepts input beats, tracks length and running sum, classifies
module cfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [23:0]   s_axis_tdata_i,   // frame_command, payload_length, data_byte
  input  logic          s_axis_tuser_i,   // action
  output logic          push_valid_o,
  output cfb_pkg::rec_t push_rec_o,
  input  logic          push_ready_i
);

  logic [7:0] rem_q, rem_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cmd, len, dat, len_byte, sum_a;
  logic       accept;

  assign cmd      = s_axis_tdata_i[7:0];
  assign len      = s_axis_tdata_i[15:8];
  assign dat      = s_axis_tdata_i[23:16];
  assign len_byte = len + cfb_pkg::LEN_OFFSET;
  assign sum_a    = sum_q + dat;

  assign s_axis_tready_o = push_ready_i;
  assign accept          = s_axis_tvalid_i && push_ready_i;

  always_comb begin
    push_valid_o = 1'b0;
    push_rec_o   = '0;
    rem_d        = rem_q;
    sum_d        = sum_q;
    if (accept) begin
      if (s_axis_tuser_i == cfb_pkg::ACT_START) begin
        push_valid_o      = 1'b1;
        push_rec_o.start  = 1'b1;
        push_rec_o.byte_a = len_byte;
        push_rec_o.cmd    = cmd;
        push_rec_o.close  = (len == cfb_pkg::ZERO_BYTE);
        push_rec_o.csum   = len_byte + cmd;
        rem_d             = len;
        sum_d             = len_byte + cmd;
      end else if (rem_q != cfb_pkg::ZERO_BYTE) begin
        // payload beats past the length are dropped
        push_valid_o      = 1'b1;
        push_rec_o.byte_a = dat;
        push_rec_o.stuff  = (dat == cfb_pkg::STUFF_TRIGGER);
        push_rec_o.close  = (rem_q == 8'd1);
        sum_d             = push_rec_o.stuff ? sum_a + cfb_pkg::STUFF_BYTE : sum_a;
        push_rec_o.csum   = sum_d;
        rem_d             = rem_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      sum_q <= '0;
    end else begin
      rem_q <= rem_d;
      sum_q <= sum_d;
    end
  end

endmodule

// ===== hw/rtl/cfb_queue.sv =====
// short record queue between front and back
module cfb_queue #(
  parameter int unsigned Depth = cfb_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  cfb_pkg::rec_t push_rec_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output cfb_pkg::rec_t pop_rec_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cfb_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_rec_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

endmodule

// ===== hw/rtl/cfb_back.sv =====
// back end: expands records into wire bytes, holds sync registers and output stage
module cfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          rec_valid_i,
  input  cfb_pkg::rec_t rec_i,
  output logic          rec_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,
  output logic          m_axis_tlast_o
);

  cfb_pkg::back_state_e state_q, state_d;
  cfb_pkg::rec_t        cur_q;
  logic [3:0]           idx_q, idx_d;
  logic [7:0]           hdr0_q, hdr1_q;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free, emit;
  logic [7:0]           nbyte;
  logic                 nlast;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign emit      = out_free && ((state_q != cfb_pkg::ST_IDLE) || rec_valid_i);
  assign rec_pop_o = out_free && (state_q == cfb_pkg::ST_IDLE) && rec_valid_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    nbyte   = cfb_pkg::ZERO_BYTE;
    nlast   = 1'b0;
    case (state_q)
      cfb_pkg::ST_IDLE: begin
        if (rec_i.start) begin
          nbyte   = hdr0_q;
          idx_d   = cfb_pkg::HEAD_SECOND_IDX;
          state_d = cfb_pkg::ST_HEAD;
        end else begin
          nbyte = rec_i.byte_a;
          if (rec_i.stuff) begin
            state_d = cfb_pkg::ST_DATA_STUFF;
          end else if (rec_i.close) begin
            state_d = cfb_pkg::ST_CSUM;
          end
        end
      end
      cfb_pkg::ST_HEAD: begin
        case (idx_q)
          cfb_pkg::HEAD_SECOND_IDX: nbyte = hdr1_q;
          cfb_pkg::HEAD_LEN_IDX:    nbyte = cur_q.byte_a;
          cfb_pkg::HEAD_LAST_IDX:   nbyte = cur_q.cmd;
          default:                  nbyte = cfb_pkg::ZERO_BYTE;
        endcase
        if (idx_q == cfb_pkg::HEAD_LAST_IDX) begin
          state_d = cur_q.close ? cfb_pkg::ST_CSUM : cfb_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      cfb_pkg::ST_DATA_STUFF: begin
        nbyte   = cfb_pkg::STUFF_BYTE;
        state_d = cur_q.close ? cfb_pkg::ST_CSUM : cfb_pkg::ST_IDLE;
      end
      cfb_pkg::ST_CSUM: begin
        nbyte = cur_q.csum;
        if (cur_q.csum == cfb_pkg::STUFF_TRIGGER) begin
          state_d = cfb_pkg::ST_CSUM_STUFF;
        end else begin
          nlast   = 1'b1;
          state_d = cfb_pkg::ST_IDLE;
        end
      end
      cfb_pkg::ST_CSUM_STUFF: begin
        nbyte   = cfb_pkg::STUFF_BYTE;
        nlast   = 1'b1;
        state_d = cfb_pkg::ST_IDLE;
      end
      default: begin
        state_d = cfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = nbyte;
      out_last_d  = nlast;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfb_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      hdr0_q      <= cfb_pkg::STUFF_TRIGGER;
      hdr1_q      <= cfb_pkg::STUFF_TRIGGER;
    end else begin
      if (emit) begin
        state_q <= state_d;
        idx_q   <= idx_d;
      end
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          cfb_pkg::REG_FIRST_HDR:  hdr0_q <= cfg_wdata_i;
          cfb_pkg::REG_SECOND_HDR: hdr1_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (rec_pop_o) begin
      cur_q <= rec_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/checksummed_frame_builder_ff_stuffing.sv =====
// top level: byte-stuffed link frame builder with additive checksum
// an accepted beat is queued as a record, then its first byte is registered at the output
// throughput: one byte per cycle from the back sequencer unless the output stalls; a start
//   beat gives 10 to 12 bytes, a payload beat 1 to 4; input runs ahead by the queue depth
// input beats are taken one per cycle while the record queue has room
// reset: asynchronous active low, clears length, sum, queue and output stage;
//   both sync bytes return to 0xff
module checksummed_frame_builder_ff_stuffing #(
  parameter int unsigned QueueDepth = cfb_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes, index 0 first sync byte, index 1 second sync byte
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // frame_command, payload_length, data_byte
  input  logic        s_axis_tuser_i,   // action
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte
  output logic        m_axis_tlast_o    // frame_end
);

  // classified records from front to queue
  logic          push_valid, push_ready;
  cfb_pkg::rec_t push_rec;
  // records from queue to back
  logic          pop_valid, pop;
  cfb_pkg::rec_t pop_rec;

  // front keeps the remaining count and running sum, so the checksum is known on entry
  cfb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_valid_o    (push_valid),
    .push_rec_o      (push_rec),
    .push_ready_i    (push_ready)
  );

  // decouples input acceptance from byte expansion
  cfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_rec_i   (push_rec),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_rec_o    (pop_rec),
    .pop_i        (pop)
  );

  // back sequencer walks header, payload, stuff and checksum bytes
  cfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rec_valid_i     (pop_valid),
    .rec_i           (pop_rec),
    .rec_pop_o       (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== hw/rtl/cfb_checker.sv =====
// port-level checker for the frame builder, bound to the top level
`include "checksummed_frame_builder_ff_stuffing_assert.svh"

module cfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // a stalled output beat holds
  `CFB_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output beat changed while stalled")

  // a checksum of 0xff is never the closing byte, its stuff byte is
  `CFB_ASSERT(a_last_not_trigger, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o != 8'hFF, "frame closed on an unstuffed 0xff")

  // output stage is empty by the edge after reset is seen
  `CFB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")

  // output stage empties only after its beat was taken
  `CFB_ASSERT(a_no_drop, clk_i, rst_ni, $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i), "output beat dropped")

endmodule

bind checksummed_frame_builder_ff_stuffing cfb_checker u_cfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
